>>> design/text_hex_base64_payload_decoder_assert.svh
// Assertion macros used by the checker file of the payload decoder.
`ifndef TEXT_HEX_BASE64_PAYLOAD_DECODER_ASSERT_SVH
`define TEXT_HEX_BASE64_PAYLOAD_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define THBDEC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("payload decoder check failed");

// Next-cycle implication, disabled while reset is asserted.
`define THBDEC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("payload decoder check failed");

`endif

>>> design/thbdec_pkg.sv
`default_nettype none

package thbdec_pkg;

  // Mode register codes
  localparam logic [1:0] ModeText = 2'd0;
  localparam logic [1:0] ModeHex  = 2'd1;
  localparam logic [1:0] ModeB64  = 2'd2;

  // Result kinds
  localparam logic [1:0] KindData    = 2'd0;
  localparam logic [1:0] KindEnd     = 2'd1;
  localparam logic [1:0] KindBadChar = 2'd2;
  localparam logic [1:0] KindOddHex  = 2'd3;

  localparam logic [7:0] CharPad = 8'h3D;

  typedef struct packed {
    logic [7:0] character;
    logic       end_of_payload;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [1:0] kind;
    logic       last;
  } out_item_t;

  // Character classification handed from the classifier to the decoder core
  typedef struct packed {
    logic       hex_ok;
    logic [3:0] hex_val;
    logic       b64_ok;
    logic       b64_pad;
    logic [5:0] b64_val;
  } char_class_t;

endpackage

`default_nettype wire

>>> design/thbdec_char_class.sv
`default_nettype none

module thbdec_char_class (
  input  logic [7:0]               char_i,
  output thbdec_pkg::char_class_t  class_o
);
  import thbdec_pkg::*;

  always_comb begin
    class_o = '0;
    // hex digits
    if (char_i >= 8'h30 && char_i <= 8'h39) begin
      class_o.hex_ok  = 1'b1;
      class_o.hex_val = 4'(char_i - 8'h30);
    end else if (char_i >= 8'h61 && char_i <= 8'h66) begin
      class_o.hex_ok  = 1'b1;
      class_o.hex_val = 4'(char_i - 8'h57);
    end else if (char_i >= 8'h41 && char_i <= 8'h46) begin
      class_o.hex_ok  = 1'b1;
      class_o.hex_val = 4'(char_i - 8'h37);
    end
    // base64 alphabet
    if (char_i >= 8'h41 && char_i <= 8'h5A) begin
      class_o.b64_ok  = 1'b1;
      class_o.b64_val = 6'(char_i - 8'h41);
    end else if (char_i >= 8'h61 && char_i <= 8'h7A) begin
      class_o.b64_ok  = 1'b1;
      class_o.b64_val = 6'(char_i - 8'h47);
    end else if (char_i >= 8'h30 && char_i <= 8'h39) begin
      class_o.b64_ok  = 1'b1;
      class_o.b64_val = 6'(char_i + 8'h04);
    end else if (char_i == 8'h2B) begin
      class_o.b64_ok  = 1'b1;
      class_o.b64_val = 6'd62;
    end else if (char_i == 8'h2F) begin
      class_o.b64_ok  = 1'b1;
      class_o.b64_val = 6'd63;
    end
    class_o.b64_pad = (char_i == CharPad);
  end

endmodule

`default_nettype wire

>>> design/text_hex_base64_payload_decoder.sv
// Payload character decoder: text pass-through, hex pairs or base64.
// Input channel: one character per request with an end-of-payload flag,
//   in_valid_i / in_stall_o; a request is taken when valid is high and
//   stall is low. Output channel: at most one result per character,
//   out_valid_o / out_stall_i, carrying a byte, a kind and a last flag.
// Configuration: cfg_valid_i / cfg_ready_o writes the 2-bit mode; write it
//   only between payloads, with the block drained.
// Pipeline: a taken request sits in the input register, is decoded, and
//   its result is registered (one input register, one result register).
//   Throughput: one character per cycle while the result register is not
//   held, set by the single decode step between the two registers.
// Characters that give no result (first hex digit, first base64 sextet,
//   anything after an error or a pad) still move through the input register.
// Stall: while the result register is held, the input register keeps its
//   request and in_stall_o rises; a character that gives no result still
//   moves through.
// Reset: clears valids, mode (text) and all per-payload decode state.
`default_nettype none

module text_hex_base64_payload_decoder (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  thbdec_pkg::in_item_t   in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output thbdec_pkg::out_item_t  out_data_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [1:0]             cfg_data_i
);
  import thbdec_pkg::*;

  // handshake and pipeline control
  logic        in_valid_q, in_valid_d;
  in_item_t    in_item_q;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_item_q;
  logic        in_take;
  logic        out_free;
  logic        advance;

  // configuration
  logic [1:0]  mode_q;

  // per-payload decode state
  logic [11:0] acc_q, acc_d;
  logic [2:0]  held_q, held_d;
  logic [3:0]  hi_q, hi_d;
  logic        pend_q, pend_d;
  logic        pad_q, pad_d;
  logic        err_q, err_d;

  // decode step
  char_class_t cls;
  logic        res_valid;
  out_item_t   res;
  logic [11:0] acc_new;
  logic [3:0]  held_sum;
  logic [2:0]  held_left;
  logic        last_char;

  thbdec_char_class u_char_class (
    .char_i  (in_item_q.character),
    .class_o (cls)
  );

  // The result register empties when it is taken or holds nothing.
  assign out_free   = !out_valid_q || !out_stall_i;
  // A character with a result needs room; one without moves freely.
  assign advance    = in_valid_q && (!res_valid || out_free);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;
  assign in_valid_d = in_take || (in_valid_q && !advance);

  assign cfg_ready_o = 1'b1;

  assign last_char = in_item_q.end_of_payload;
  assign acc_new   = {acc_q[5:0], cls.b64_val};
  assign held_sum  = {1'b0, held_q} + 4'd6;
  assign held_left = 3'(held_sum - 4'd8);

  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    acc_d     = acc_q;
    held_d    = held_q;
    hi_d      = hi_q;
    pend_d    = pend_q;
    pad_d     = pad_q;
    err_d     = err_q;

    if (pad_q || err_q) begin
      // drop the rest of the payload silently
    end else begin
      case (mode_q)
        ModeHex: begin
          if (!cls.hex_ok) begin
            res_valid = 1'b1;
            res.kind  = KindBadChar;
            res.last  = 1'b1;
            err_d     = 1'b1;
          end else if (pend_q) begin
            res_valid     = 1'b1;
            res.data_byte = {hi_q, cls.hex_val};
            res.kind      = KindData;
            res.last      = last_char;
            pend_d        = 1'b0;
            hi_d          = '0;
          end else if (last_char) begin
            res_valid = 1'b1;
            res.kind  = KindOddHex;
            res.last  = 1'b1;
          end else begin
            hi_d   = cls.hex_val;
            pend_d = 1'b1;
          end
        end
        ModeB64: begin
          if (cls.b64_pad) begin
            res_valid = 1'b1;
            res.kind  = KindEnd;
            res.last  = 1'b1;
            pad_d     = 1'b1;
          end else if (!cls.b64_ok) begin
            res_valid = 1'b1;
            res.kind  = KindBadChar;
            res.last  = 1'b1;
            err_d     = 1'b1;
          end else begin
            acc_d = acc_new;
            if (held_sum >= 4'd8) begin
              // a byte is complete: its top sits held_left bits above bit 7
              res_valid = 1'b1;
              res.kind  = KindData;
              res.last  = last_char;
              held_d    = held_left;
              case (held_left)
                3'd4:    res.data_byte = acc_new[11:4];
                3'd2:    res.data_byte = acc_new[9:2];
                default: res.data_byte = acc_new[7:0];
              endcase
            end else begin
              held_d = 3'(held_sum);
              if (last_char) begin
                res_valid = 1'b1;
                res.kind  = KindEnd;
                res.last  = 1'b1;
              end
            end
          end
        end
        default: begin
          // text pass-through, unused mode included
          res_valid     = 1'b1;
          res.data_byte = in_item_q.character;
          res.kind      = KindData;
          res.last      = last_char;
        end
      endcase
    end

    // the final character returns the payload state to reset
    if (last_char) begin
      acc_d  = '0;
      held_d = '0;
      hi_d   = '0;
      pend_d = 1'b0;
      pad_d  = 1'b0;
      err_d  = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = advance && res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mode_q      <= ModeText;
      acc_q       <= '0;
      held_q      <= '0;
      hi_q        <= '0;
      pend_q      <= 1'b0;
      pad_q       <= 1'b0;
      err_q       <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        mode_q <= cfg_data_i;
      end
      if (advance) begin
        acc_q  <= acc_d;
        held_q <= held_d;
        hi_q   <= hi_d;
        pend_q <= pend_d;
        pad_q  <= pad_d;
        err_q  <= err_d;
      end
    end
  end

  // payload registers: load on a taken request or a new result, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= in_data_i;
    end
    if (advance && res_valid && out_free) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

endmodule

`default_nettype wire

>>> design/thbdec_checker.sv
`default_nettype none
`include "text_hex_base64_payload_decoder_assert.svh"

module thbdec_checker (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input thbdec_pkg::out_item_t  out_data_o
);
  import thbdec_pkg::*;

  logic non_data;
  assign non_data = out_data_o.kind != KindData;

  // a held result stays offered
  `THBDEC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  // errors and end markers always close the payload
  `THBDEC_ASSERT_NOW(a_non_data_last, clk_i, rst_ni, out_valid_o && non_data, out_data_o.last)
  // only data results carry a byte
  `THBDEC_ASSERT_NOW(a_non_data_zero, clk_i, rst_ni, out_valid_o && non_data,
                     out_data_o.data_byte == 8'h00)
  // with the result register empty the input side never stalls
  `THBDEC_ASSERT_NOW(a_no_idle_stall, clk_i, rst_ni, !out_valid_o, !in_stall_o)

endmodule

bind text_hex_base64_payload_decoder thbdec_checker u_thbdec_checker (.*);

`default_nettype wire
